// ===== hw/rtl/sba_pkg.sv =====
// Shared types for the slot bitmap allocator: command and status codes.
// No dependencies; imported by the allocator and its checker.
package sba_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_SET   = 2'd2,
		CMD_GET   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_RESOURCES = 2'd1,
		ST_OUT_OF_BOUNDS = 2'd2,
		ST_NOT_IN_USE   = 2'd3
	} status_t;

	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned THREAD_W = 5;
	localparam int unsigned VALUE_W  = 32;

endpackage

// ===== hw/rtl/slot_bitmap_allocator_with_values.sv =====
// Slot bitmap allocator with a per-thread value store.
// Depends on sba_pkg for command and status codes.
//
// Usage: a command word enters on the input channel (command, slot, value,
// thread) and is taken at a rising edge where in_valid is high and in_stall
// is low. Each command produces exactly one result word (status, slot_index,
// read_value) on the output channel, taken where out_valid is high and
// out_stall is low. Allocate grants the lowest free slot; free releases a
// slot; set and get write and read one 32-bit word at (thread, slot).
// An accepted command passes stage 1 and then the output register before its
// result shows on out_valid. One command is taken every cycle while in_stall
// is low: the in-use bitmap is resolved in the accept cycle by a priority
// encoder, and the value store's single read/write port does one access per command.
// A set followed directly by a get of the same word needs no forwarding,
// since the write lands at the accept edge before the next read is issued.
// At reset the bitmap clears at once, and the value store is zeroed by a
// sweep over all THREADS*SLOTS words (2048 at the defaults), one word per cycle;
// in_stall stays high for that whole sweep. When the receiver stalls, the
// result word holds in the output register, one more result waits in the
// stage behind it, and only then does in_stall rise.
module slot_bitmap_allocator_with_values #(
	parameter int SLOTS   = 64,
	parameter int THREADS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sba_pkg::cmd_t                 command,
	input  logic [sba_pkg::SLOT_W-1:0]    slot,
	input  logic [sba_pkg::VALUE_W-1:0]   value,
	input  logic [sba_pkg::THREAD_W-1:0]  thread,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sba_pkg::status_t              status,
	output logic [sba_pkg::SLOT_W-1:0]    slot_index,
	output logic [sba_pkg::VALUE_W-1:0]   read_value
);
	import sba_pkg::*;

	localparam int DEPTH = THREADS * SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Control and bitmap state.
	logic             clearing_q;
	logic [AW-1:0]    clr_cnt_q;
	logic [SLOTS-1:0] in_use_q;

	// Stage 1 holds a decided command while the store read completes.
	logic             valid_s1;
	status_t          status_s1;
	logic [SLOT_W-1:0] slot_index_s1;
	logic             get_s1;
	logic [VALUE_W-1:0] mem_rd_s1;

	// Output register.
	logic               out_valid_q;
	status_t            status_q;
	logic [SLOT_W-1:0]  slot_index_q;
	logic [VALUE_W-1:0] read_value_q;

	// The value store itself: one port, read data registered.
	logic [VALUE_W-1:0] mem [DEPTH];

	logic          accept;
	logic          adv_s1;
	logic          slot_in_range;
	logic          slot_used;
	logic          thread_in_range;
	logic          free_found;
	logic [SW-1:0] free_sel;
	logic [AW-1:0] cmd_addr;
	status_t       dec_status;
	logic          map_set;
	logic          map_clr;
	logic          cmd_we;
	logic          cmd_re;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;

	// The stage behind the output register moves whenever the output is free
	// or is being taken this cycle.
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !adv_s1);
	assign accept   = in_valid && !in_stall;

	assign slot_in_range   = {1'b0, slot} < 7'(SLOTS);
	assign slot_used       = in_use_q[slot[SW-1:0]];
	assign thread_in_range = {4'b0, thread} < 9'(THREADS);
	assign cmd_addr        = AW'(32'(thread) * SLOTS + 32'(slot));

	// Lowest free slot. Scanning from the top lets the lowest hit win.
	always_comb begin
		free_found = 1'b0;
		free_sel   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_sel   = SW'(i);
			end
		end
	end

	// Command decode. Slot checks come before the thread check, and free
	// never looks at the thread.
	always_comb begin
		dec_status = ST_OK;
		map_set    = 1'b0;
		map_clr    = 1'b0;
		cmd_we     = 1'b0;
		cmd_re     = 1'b0;
		unique case (command) inside
			CMD_ALLOC: begin
				if (free_found) begin
					map_set = 1'b1;
				end else begin
					dec_status = ST_NO_RESOURCES;
				end
			end
			CMD_FREE, CMD_SET, CMD_GET: begin
				if (!slot_in_range) begin
					dec_status = ST_OUT_OF_BOUNDS;
				end else if (!slot_used) begin
					dec_status = ST_NOT_IN_USE;
				end else if (command == CMD_FREE) begin
					map_clr = 1'b1;
				end else if (!thread_in_range) begin
					dec_status = ST_OUT_OF_BOUNDS;
				end else if (command == CMD_SET) begin
					cmd_we = 1'b1;
				end else begin
					cmd_re = 1'b1;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// The reset sweep owns the write port until it finishes; no command is
	// accepted meanwhile.
	assign mem_we    = clearing_q || (accept && cmd_we);
	assign mem_waddr = clearing_q ? clr_cnt_q : cmd_addr;
	assign mem_wdata = clearing_q ? '0 : value;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept && cmd_re) begin
			mem_rd_s1 <= mem[cmd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (accept) begin
			if (map_set) begin
				in_use_q[free_sel] <= 1'b1;
			end
			if (map_clr) begin
				in_use_q[slot[SW-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1     <= dec_status;
			slot_index_s1 <= (command == CMD_ALLOC && free_found) ? SLOT_W'(free_sel) : '0;
			get_s1        <= cmd_re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q     <= status_s1;
			slot_index_q <= slot_index_s1;
			read_value_q <= get_s1 ? mem_rd_s1 : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;
	assign read_value = read_value_q;

endmodule

// ===== hw/rtl/sba_checker.sv =====
// Port-level checks for the slot bitmap allocator, bound to its top level.
// Depends on sba_pkg for the status codes.
module sba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input sba_pkg::status_t              status,
	input logic [sba_pkg::SLOT_W-1:0]    slot_index,
	input logic [sba_pkg::VALUE_W-1:0]   read_value
);
	import sba_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(slot_index) && $stable(read_value))
		else $error("result word changed while stalled");

	// Every accepted command is followed by out_valid high on the output channel.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted command produced no result in time");

	// Failed commands return zeroed index and data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> slot_index == '0 && read_value == '0)
		else $error("error result carries nonzero payload");

endmodule

bind slot_bitmap_allocator_with_values sba_checker u_sba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.slot_index (slot_index),
	.read_value (read_value)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for slot_bitmap_allocator_with_values.
// Depends on sba_pkg and the allocator RTL. It carries its own predictor of the bitmap and value store.
module tb_top;
	import sba_pkg::*;

	localparam int NUM_SLOTS    = 64;
	localparam int NUM_THREADS  = 32;
	localparam int RANDOM_WORDS = 2000;
	// The value store sweep after reset keeps in_stall high throughout, and idle_span
	// bounds the longest stall run. Both fit well inside this limit.
	localparam int IDLE_LIMIT   = 12000;

	// One reply word, as the allocator presents it on the output channel.
	typedef struct packed {
		status_t                 status;
		logic [SLOT_W-1:0]       slot_index;
		logic [VALUE_W-1:0]      read_value;
	} reply_word_t;

	// The scoreboard holds a private copy of the slot bitmap and the value store.
	// Each accepted command is applied to that copy at once, and the reply it must
	// produce is queued. Replies leave in command order, one per command, so each
	// reply that arrives is compared with the oldest queued entry.
	class allocator_scoreboard;
		logic [NUM_SLOTS-1:0] slot_busy;
		logic [VALUE_W-1:0]   word_mem [NUM_THREADS][NUM_SLOTS];
		reply_word_t          awaited_replies [$];
		int                   errors;

		function new();
			slot_busy = '0;
			errors    = 0;
			foreach (word_mem[t, s])
				word_mem[t][s] = '0;
		endfunction

		// Applies one command to the shadow state and returns the reply it causes.
		function reply_word_t apply_command(cmd_t cmd, logic [SLOT_W-1:0] slot,
				logic [VALUE_W-1:0] value, logic [THREAD_W-1:0] thread);
			reply_word_t r;
			bit          found;
			r     = '{status: ST_OK, slot_index: '0, read_value: '0};
			found = 0;
			if (cmd == CMD_ALLOC) begin
				// The lowest free slot wins. Every other field of the command is ignored.
				for (int i = 0; i < NUM_SLOTS && !found; i++) begin
					if (!slot_busy[i]) begin
						slot_busy[i] = 1'b1;
						r.slot_index = SLOT_W'(i);
						found = 1;
					end
				end
				if (!found)
					r.status = ST_NO_RESOURCES;
			end else if (int'(slot) >= NUM_SLOTS) begin
				r.status = ST_OUT_OF_BOUNDS;
			end else if (!slot_busy[slot]) begin
				r.status = ST_NOT_IN_USE;
			end else if (cmd == CMD_FREE) begin
				// Freeing a slot leaves the words stored under it untouched.
				slot_busy[slot] = 1'b0;
			end else if (int'(thread) >= NUM_THREADS) begin
				r.status = ST_OUT_OF_BOUNDS;
			end else if (cmd == CMD_SET) begin
				word_mem[thread][slot] = value;
			end else begin
				r.read_value = word_mem[thread][slot];
			end
			return r;
		endfunction

		function void note_command(cmd_t cmd, logic [SLOT_W-1:0] slot,
				logic [VALUE_W-1:0] value, logic [THREAD_W-1:0] thread);
			awaited_replies.push_back(apply_command(cmd, slot, value, thread));
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_reply(status_t status, logic [SLOT_W-1:0] slot_index,
				logic [VALUE_W-1:0] read_value);
			reply_word_t want;
			if (awaited_replies.size() == 0) begin
				errors++;
				$display("%0t: reply word with none expected: expected nothing, actual %0d/%0h/%0h",
					$time, status, slot_index, read_value);
				return;
			end
			want = awaited_replies.pop_front();
			compare_field("status", 32'(want.status), 32'(status));
			compare_field("slot_index", 32'(want.slot_index), 32'(slot_index));
			compare_field("read_value", want.read_value, read_value);
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	cmd_t                command    = CMD_ALLOC;
	logic [SLOT_W-1:0]   slot       = '0;
	logic [VALUE_W-1:0]  value      = '0;
	logic [THREAD_W-1:0] thread     = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	status_t             status;
	logic [SLOT_W-1:0]   slot_index;
	logic [VALUE_W-1:0]  read_value;

	allocator_scoreboard sb = new();

	// When set, the command side sends back to back. When clear, it leaves random gaps.
	bit in_quiet  = 0;
	// When set, the reply side starts no new stall runs.
	bit out_quiet = 0;
	// The stimulus leans toward allocate while filling, and toward free while draining.
	bit filling   = 1;

	slot_bitmap_allocator_with_values #(
		.SLOTS   (NUM_SLOTS),
		.THREADS (NUM_THREADS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.slot       (slot),
		.value      (value),
		.thread     (thread),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot_index (slot_index),
		.read_value (read_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Length of an idle run. Most runs are zero or short, and a few are long.
	function automatic int idle_span();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 5);
	endfunction

	// Sends one command word and returns once the allocator has taken it. The valid
	// signal is lowered only when a gap is about to follow. This way back-to-back words
	// never see in_valid dropped and raised within the same time step.
	task automatic send_word(cmd_t c, logic [SLOT_W-1:0] s, logic [VALUE_W-1:0] v,
			logic [THREAD_W-1:0] t);
		int gap;
		gap = in_quiet ? 0 : idle_span();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= c;
		slot     <= s;
		value    <= v;
		thread   <= t;
		// Signals read right after the edge still hold the values they had at that edge.
		// in_stall is therefore the value that decides whether the word was taken.
		do
			@(posedge clk);
		while (in_stall);
		sb.note_command(c, s, v, t);
	endtask

	// Picks one random command, shaped around the current bitmap. Most free, set and
	// get commands aim at slots in use, so they pass the in-use check. The rest pick
	// any slot, and those that land on a free slot take the not-in-use path. Threads
	// cluster on a few rows so that a get often reads back an earlier set.
	task automatic send_random_word();
		int                  held [$];
		int                  roll;
		cmd_t                c;
		logic [SLOT_W-1:0]   s;
		logic [THREAD_W-1:0] t;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (sb.slot_busy[i])
				held.push_back(i);

		// Swing between filling and draining. This reaches a full map and an empty one.
		if (held.size() == NUM_SLOTS && $urandom_range(7) == 0)
			filling = 0;
		else if (held.size() == 0 || $urandom_range(299) == 0)
			filling = 1;

		roll = $urandom_range(99);
		if (roll < (filling ? 45 : 12))
			c = CMD_ALLOC;
		else if (roll < (filling ? 55 : 50))
			c = CMD_FREE;
		else if (roll < (filling ? 78 : 75))
			c = CMD_SET;
		else
			c = CMD_GET;

		if (held.size() > 0 && $urandom_range(99) < 85)
			s = SLOT_W'(held[$urandom_range(held.size() - 1)]);
		else
			s = SLOT_W'($urandom_range(NUM_SLOTS - 1));

		if ($urandom_range(99) < 70)
			t = THREAD_W'($urandom_range(3));
		else
			t = THREAD_W'($urandom_range(NUM_THREADS - 1));

		// Noise: now and then a command with every field drawn blindly.
		if ($urandom_range(9) == 0) begin
			c = cmd_t'($urandom_range(3));
			s = SLOT_W'($urandom);
			t = THREAD_W'($urandom);
		end

		send_word(c, s, $urandom, t);
	endtask

	// Command stimulus: a directed opening, then the random run, then the drain.
	initial begin : command_side
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Commands on slots that were never allocated are all refused.
		send_word(CMD_GET,   6'd0,  32'h0000_0000, 5'd0);
		send_word(CMD_FREE,  6'd63, 32'h0000_0000, 5'd0);
		send_word(CMD_SET,   6'd5,  32'hFFFF_FFFF, 5'd31);
		// Allocate ignores slot, value and thread, even at their extremes.
		send_word(CMD_ALLOC, 6'd63, 32'hFFFF_FFFF, 5'd31);
		send_word(CMD_ALLOC, 6'd0,  32'h0000_0000, 5'd0);
		send_word(CMD_ALLOC, 6'd21, 32'h1234_5678, 5'd9);
		// A fresh slot reads back the zero left by the reset sweep.
		send_word(CMD_GET,   6'd2,  32'h0000_0000, 5'd0);
		send_word(CMD_SET,   6'd2,  32'hFFFF_FFFF, 5'd31);
		send_word(CMD_GET,   6'd2,  32'h0000_0000, 5'd31);
		send_word(CMD_SET,   6'd0,  32'h0000_0000, 5'd0);
		send_word(CMD_GET,   6'd0,  32'hFFFF_FFFF, 5'd0);
		// A value written before a free is still there after the slot is allocated again.
		send_word(CMD_SET,   6'd1,  32'hA5A5_5A5A, 5'd5);
		send_word(CMD_FREE,  6'd1,  32'h0000_0000, 5'd0);
		send_word(CMD_FREE,  6'd1,  32'h0000_0000, 5'd0);
		send_word(CMD_GET,   6'd1,  32'h0000_0000, 5'd5);
		send_word(CMD_ALLOC, 6'd0,  32'h0000_0000, 5'd0);
		send_word(CMD_GET,   6'd1,  32'h0000_0000, 5'd5);
		send_word(CMD_SET,   6'd1,  32'h8000_0001, 5'd31);
		send_word(CMD_GET,   6'd63, 32'h0000_0000, 5'd31);
		// Freeing the lowest slot makes the next allocate hand it out again.
		send_word(CMD_FREE,  6'd0,  32'h0000_0000, 5'd0);
		send_word(CMD_ALLOC, 6'd40, 32'h0000_0000, 5'd16);
		send_word(CMD_GET,   6'd0,  32'h0000_0000, 5'd0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0)
				in_quiet = ($urandom_range(3) == 0);
			send_random_word();
		end
		in_valid <= 1'b0;

		// The watchdog bounds this wait. The extra cycles leave room for any stray
		// reply that comes after the last expected one.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** slot_bitmap_allocator_with_values: PASSED **");
		else
			$display("** slot_bitmap_allocator_with_values: FAILED **");
		$finish;
	end

	// Reply side: checks each reply word as it is taken, then drives out_stall.
	// After each cycle without a stall, a random stall run may follow.
	initial begin : reply_side
		int  stall_left;
		int  cycles;
		bit  next_stall;
		stall_left = 0;
		cycles     = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_reply(status, slot_index, read_value);
			cycles++;
			if (cycles % 500 == 0)
				out_quiet = ($urandom_range(3) == 0);
			if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else begin
				next_stall = 1'b0;
				stall_left = out_quiet ? 0 : idle_span();
			end
			out_stall <= next_stall;
		end
	end

	// Watchdog: the run fails if no word moves on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
		$display("** slot_bitmap_allocator_with_values: FAILED **");
		$finish;
	end

endmodule
